// File: rtl/dlc_pkg.sv
// Package with the shared constants, register map and helper functions of the door lock.
`timescale 1ns / 1ps
`default_nettype none
package dlc_pkg;

    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int UID_W   = 32;
    localparam int LEN_W   = 4;
    localparam int CNTS_W  = 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [2:0] REG_AUTO_CLOSE = 3'd1;
    localparam logic [2:0] REG_ANY_CARD   = 3'd2;
    localparam logic [2:0] REG_UID_FIRST  = 3'd3;
    localparam logic [2:0] REG_UID_SECOND = 3'd4;
    localparam logic [2:0] REG_UID_COUNT  = 3'd5;

    localparam logic [CFG_W-1:0]  DEBOUNCE_RST   = CFG_W'(40);
    localparam logic [CFG_W-1:0]  AUTO_CLOSE_RST = CFG_W'(5000);
    localparam logic [UID_W-1:0]  UID_FIRST_RST  = 32'h0102_0304;
    localparam logic [UID_W-1:0]  UID_SECOND_RST = 32'hDEAD_BEEF;
    localparam logic [CNTS_W-1:0] UID_COUNT_RST  = 2'd2;
    localparam logic [LEN_W-1:0]  UID_LEN_TABLE  = 4'd4;

    typedef struct packed {
        logic last;
        logic stable;
        logic [CNT_W-1:0] quiet;
    } deb_state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

// File: rtl/door_lock_controller.sv
// Top level of the door lock: button debounce, card check, auto-close and the config port.
//
//   Channel   Direction  Width  Contents
//   s_*       in         40     one millisecond tick: buttons and card read
//   m_*       out        8      lock state and event flags after the tick
//   APB       in/out     32     six configuration registers at 4-byte steps
//
// Each tick is handled combinationally: the next state and the result are computed
// from s_tdata and the state registers and written into the result register.
// A new transaction is taken every cycle while the result register is empty or
// being drained, so a stall on m_* holds s_* only once the result register is full.
// Reset (aresetn low at a clock edge) restores the released, locked state and the
// default register values.
`timescale 1ns / 1ps
`default_nettype none
module door_lock_controller (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [0] open_button_level, [1] close_button_level, [2] card_present,
    // [6:3] card_uid_length, [38:7] card_uid, [39] zero
    input  wire logic [dlc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [0] door_open, [1] opened_by_button, [2] opened_by_card,
    // [3] closed_by_button, [4] closed_by_timeout, [5] card_rejected, [7:6] zero
    output logic [dlc_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dlc_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [dlc_pkg::DATA_W-1:0]       pwdata,
    output logic [dlc_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready
);

    logic [dlc_pkg::CFG_W-1:0]  debounce_ticks_reg;
    logic [dlc_pkg::CFG_W-1:0]  auto_close_ticks_reg;
    logic                       accept_any_card_reg;
    logic [dlc_pkg::UID_W-1:0]  uid_first_reg;
    logic [dlc_pkg::UID_W-1:0]  uid_second_reg;
    logic [dlc_pkg::CNTS_W-1:0] uid_count_reg;

    dlc_pkg::deb_state_t open_deb_reg, open_deb_next;
    dlc_pkg::deb_state_t close_deb_reg, close_deb_next;
    logic                     lock_open_reg, lock_open_next;
    logic                     armed_reg, armed_next;
    logic [dlc_pkg::CNT_W-1:0] elapsed_reg, elapsed_next;

    logic                          m_tvalid_reg;
    logic [dlc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                      open_lvl, close_lvl, card_present;
    logic [dlc_pkg::LEN_W-1:0] card_len;
    logic [dlc_pkg::UID_W-1:0] card_uid;
    logic                      open_press, close_press;
    logic                      card_ok, by_card, rejected, timeout;
    logic                      s_accept, cfg_write;
    logic [dlc_pkg::CNT_W-1:0] elapsed_mid;

    assign open_lvl     = s_tdata[0];
    assign close_lvl    = s_tdata[1];
    assign card_present = s_tdata[2];
    assign card_len     = s_tdata[6:3];
    assign card_uid     = s_tdata[38:7];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Debounce: the quiet count restarts on any level change and must exceed the threshold.
    function automatic dlc_pkg::deb_state_t deb_next(input dlc_pkg::deb_state_t cur,
                                                     input logic level,
                                                     input logic [dlc_pkg::CFG_W-1:0] limit);
        dlc_pkg::deb_state_t nxt;
        nxt.last   = level;
        nxt.quiet  = (level != cur.last) ? '0 : dlc_pkg::sat_inc(cur.quiet);
        nxt.stable = cur.stable;
        if ((dlc_pkg::CMP_W'(nxt.quiet) > dlc_pkg::CMP_W'(limit)) && (level != cur.stable)) begin
            nxt.stable = level;
        end
        return nxt;
    endfunction

    always_comb begin
        open_deb_next  = deb_next(open_deb_reg, open_lvl, debounce_ticks_reg);
        close_deb_next = deb_next(close_deb_reg, close_lvl, debounce_ticks_reg);
        open_press  = (open_deb_next.stable != open_deb_reg.stable) && !open_lvl;
        close_press = (close_deb_next.stable != close_deb_reg.stable) && !close_lvl;

        card_ok = accept_any_card_reg ||
                  ((card_len == dlc_pkg::UID_LEN_TABLE) &&
                   (((uid_count_reg >= 2'd1) && (card_uid == uid_first_reg)) ||
                    ((uid_count_reg >= 2'd2) && (card_uid == uid_second_reg))));
        by_card  = card_present && card_ok;
        rejected = card_present && !card_ok;

        lock_open_next = lock_open_reg;
        armed_next     = armed_reg;
        if (open_press) begin
            lock_open_next = 1'b1;
            armed_next     = 1'b0;
        end
        if (close_press) begin
            lock_open_next = 1'b0;
            armed_next     = 1'b0;
        end
        elapsed_mid = elapsed_reg;
        if (by_card) begin
            lock_open_next = 1'b1;
            armed_next     = 1'b1;
            elapsed_mid    = '0;
        end

        elapsed_next = elapsed_mid;
        timeout      = 1'b0;
        if (armed_next && lock_open_next) begin
            if (!by_card) begin
                elapsed_next = dlc_pkg::sat_inc(elapsed_reg);
            end
            if (dlc_pkg::CMP_W'(elapsed_next) >= dlc_pkg::CMP_W'(auto_close_ticks_reg)) begin
                lock_open_next = 1'b0;
                armed_next     = 1'b0;
                timeout        = 1'b1;
            end
        end

        m_tdata_next = {2'b00, rejected, timeout, close_press, by_card, open_press,
                        lock_open_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_deb_reg  <= '{last: 1'b1, stable: 1'b1, quiet: '0};
            close_deb_reg <= '{last: 1'b1, stable: 1'b1, quiet: '0};
            lock_open_reg <= 1'b0;
            armed_reg     <= 1'b0;
            elapsed_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                open_deb_reg  <= open_deb_next;
                close_deb_reg <= close_deb_next;
                lock_open_reg <= lock_open_next;
                armed_reg     <= armed_next;
                elapsed_reg   <= elapsed_next;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg   <= dlc_pkg::DEBOUNCE_RST;
            auto_close_ticks_reg <= dlc_pkg::AUTO_CLOSE_RST;
            accept_any_card_reg  <= 1'b1;
            uid_first_reg        <= dlc_pkg::UID_FIRST_RST;
            uid_second_reg       <= dlc_pkg::UID_SECOND_RST;
            uid_count_reg        <= dlc_pkg::UID_COUNT_RST;
        end else if (cfg_write) begin
            case (paddr[4:2])
                dlc_pkg::REG_DEBOUNCE:   debounce_ticks_reg   <= pwdata[dlc_pkg::CFG_W-1:0];
                dlc_pkg::REG_AUTO_CLOSE: auto_close_ticks_reg <= pwdata[dlc_pkg::CFG_W-1:0];
                dlc_pkg::REG_ANY_CARD:   accept_any_card_reg  <= pwdata[0];
                dlc_pkg::REG_UID_FIRST:  uid_first_reg        <= pwdata;
                dlc_pkg::REG_UID_SECOND: uid_second_reg       <= pwdata;
                dlc_pkg::REG_UID_COUNT:  uid_count_reg        <= pwdata[dlc_pkg::CNTS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            dlc_pkg::REG_DEBOUNCE:   prdata = dlc_pkg::DATA_W'(debounce_ticks_reg);
            dlc_pkg::REG_AUTO_CLOSE: prdata = dlc_pkg::DATA_W'(auto_close_ticks_reg);
            dlc_pkg::REG_ANY_CARD:   prdata = dlc_pkg::DATA_W'(accept_any_card_reg);
            dlc_pkg::REG_UID_FIRST:  prdata = uid_first_reg;
            dlc_pkg::REG_UID_SECOND: prdata = uid_second_reg;
            dlc_pkg::REG_UID_COUNT:  prdata = dlc_pkg::DATA_W'(uid_count_reg);
            default:                 prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/dlc_checker.sv
// Port-level checker for the door lock, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dlc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dlc_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result transaction keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The input side is open whenever the result register is empty.
    assert property (@(posedge aclk) !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    // A card is either accepted or refused, never both.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[5]))
        else $error("card both accepted and rejected");

    // Auto-close is the last action of a tick, so the door ends locked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> !m_tdata[0])
        else $error("timeout close left the door open");

    // A card opening that is not followed by a timeout leaves the door open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] && !m_tdata[4] |-> m_tdata[0])
        else $error("card opening did not open the door");

endmodule

bind door_lock_controller dlc_checker u_dlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// File: tb/sv/door_lock_controller_tb.sv
// Self-checking testbench for the door lock controller: debounce, card table, auto-close.
`timescale 1ns / 1ps
module door_lock_controller_tb;
    import dlc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_PRINTED = 60;

    typedef struct packed {
        logic             pad;
        logic [UID_W-1:0] uid;
        logic [LEN_W-1:0] uid_len;
        logic             card_present;
        logic             close_level;
        logic             open_level;
    } tick_t;

    typedef struct packed {
        logic [1:0] pad;
        logic       card_rejected;
        logic       closed_by_timeout;
        logic       closed_by_button;
        logic       opened_by_card;
        logic       opened_by_button;
        logic       door_open;
    } lock_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    door_lock_controller DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Expected lock state, one entry per accepted tick.
    lock_result_t expected_results[$];
    int error_count;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;

    logic [CFG_W-1:0]  cfg_debounce;
    logic [CFG_W-1:0]  cfg_auto_close;
    logic              cfg_any_card;
    logic [UID_W-1:0]  cfg_uid_first;
    logic [UID_W-1:0]  cfg_uid_second;
    logic [CNTS_W-1:0] cfg_uid_count;

    // Index 0 is the open button, index 1 the close button.
    deb_state_t        button[2];
    logic              lock_open;
    logic              auto_armed;
    logic [CNT_W-1:0]  open_ticks;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void reset_lock_model();
        cfg_debounce   = DEBOUNCE_RST;
        cfg_auto_close = AUTO_CLOSE_RST;
        cfg_any_card   = 1'b1;
        cfg_uid_first  = UID_FIRST_RST;
        cfg_uid_second = UID_SECOND_RST;
        cfg_uid_count  = UID_COUNT_RST;
        for (int i = 0; i < 2; i++) begin
            button[i].last   = 1'b1;
            button[i].stable = 1'b1;
            button[i].quiet  = '0;
        end
        lock_open  = 1'b0;
        auto_armed = 1'b0;
        open_ticks = '0;
    endfunction

    function automatic logic debounced_press(input int idx, input logic level);
        if (level != button[idx].last) begin
            button[idx].last  = level;
            button[idx].quiet = '0;
        end else begin
            button[idx].quiet = count_up(button[idx].quiet);
        end
        if (button[idx].quiet > cfg_debounce && level != button[idx].stable) begin
            button[idx].stable = level;
            return level == 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic logic card_accepted(input tick_t t);
        if (cfg_any_card)
            return 1'b1;
        if (t.uid_len != UID_LEN_TABLE)
            return 1'b0;
        if (cfg_uid_count >= 1 && t.uid == cfg_uid_first)
            return 1'b1;
        if (cfg_uid_count >= 2 && t.uid == cfg_uid_second)
            return 1'b1;
        return 1'b0;
    endfunction

    function automatic lock_result_t predict_lock(input tick_t t);
        lock_result_t r;
        r = '0;
        if (debounced_press(0, t.open_level)) begin
            lock_open = 1'b1;
            auto_armed = 1'b0;
            r.opened_by_button = 1'b1;
        end
        if (debounced_press(1, t.close_level)) begin
            lock_open = 1'b0;
            auto_armed = 1'b0;
            r.closed_by_button = 1'b1;
        end
        if (t.card_present) begin
            if (card_accepted(t)) begin
                lock_open = 1'b1;
                auto_armed = 1'b1;
                open_ticks = '0;
                r.opened_by_card = 1'b1;
            end else begin
                r.card_rejected = 1'b1;
            end
        end
        if (auto_armed && lock_open) begin
            if (!r.opened_by_card)
                open_ticks = count_up(open_ticks);
            if (open_ticks >= cfg_auto_close) begin
                lock_open = 1'b0;
                auto_armed = 1'b0;
                r.closed_by_timeout = 1'b1;
            end
        end
        r.door_open = lock_open;
        return r;
    endfunction

    function automatic tick_t make_tick(input logic open_level, input logic close_level,
                                        input logic present, input logic [LEN_W-1:0] uid_len,
                                        input logic [UID_W-1:0] uid);
        tick_t t;
        t.pad = 1'b0;
        t.open_level = open_level;
        t.close_level = close_level;
        t.card_present = present;
        t.uid_len = uid_len;
        t.uid = uid;
        return t;
    endfunction

    // Card content leans on the table words so that matches and near misses both occur.
    function automatic tick_t random_tick(input logic open_level, input logic close_level);
        logic [UID_W-1:0] uid;
        logic [LEN_W-1:0] uid_len;
        case ($urandom_range(0, 5))
            0, 1: uid = cfg_uid_first;
            2:    uid = cfg_uid_second;
            3:    uid = cfg_uid_first ^ (32'h1 << $urandom_range(0, 31));
            default: uid = $urandom;
        endcase
        uid_len = ($urandom_range(0, 3) != 0) ? UID_LEN_TABLE : LEN_W'($urandom_range(0, 15));
        return make_tick(open_level, close_level, $urandom_range(0, 99) < 20, uid_len, uid);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int seen);
        if (error_count < MAX_PRINTED)
            $display("%0t: %s: expected %0h, got %0h", $time, what, want, seen);
        error_count++;
    endtask

    task automatic check_flag(input string what, input logic want, input logic seen);
        if (want !== seen)
            report_mismatch(what, want, seen);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    lock_result_t want_result;
    lock_result_t seen_result;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_lock(tick_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                seen_result = lock_result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no pending tick", 0, m_tdata);
                end else begin
                    want_result = expected_results.pop_front();
                    check_flag("door_open", want_result.door_open, seen_result.door_open);
                    check_flag("opened_by_button", want_result.opened_by_button,
                               seen_result.opened_by_button);
                    check_flag("opened_by_card", want_result.opened_by_card,
                               seen_result.opened_by_card);
                    check_flag("closed_by_button", want_result.closed_by_button,
                               seen_result.closed_by_button);
                    check_flag("closed_by_timeout", want_result.closed_by_timeout,
                               seen_result.closed_by_timeout);
                    check_flag("card_rejected", want_result.card_rejected,
                               seen_result.card_rejected);
                end
            end
        end
    end

    task automatic send_tick(input tick_t t);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_DEBOUNCE:   cfg_debounce   = value[CFG_W-1:0];
            REG_AUTO_CLOSE: cfg_auto_close = value[CFG_W-1:0];
            REG_ANY_CARD:   cfg_any_card   = value[0];
            REG_UID_FIRST:  cfg_uid_first  = value[UID_W-1:0];
            REG_UID_SECOND: cfg_uid_second = value[UID_W-1:0];
            REG_UID_COUNT:  cfg_uid_count  = value[CNTS_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_defaults();
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 4'hF, 32'hFFFF_FFFF));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd0, 32'h0));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 4'd4, UID_FIRST_RST));
        wait_drained();
    endtask

    task automatic test_button_debounce();
        write_reg(REG_DEBOUNCE, 0);
        write_reg(REG_AUTO_CLOSE, 0);
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 4'd0, 32'h0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0, 32'h0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0, 32'h0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0, 32'h0));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 4'd0, 32'h0));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 4'd0, 32'h0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd0, 32'h0));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd4, 32'h0));
        send_tick(make_tick(1'b1, 1'b1, 1'b0, 4'd0, 32'h0));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'hA, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    task automatic test_card_table();
        write_reg(REG_ANY_CARD, 0);
        write_reg(REG_UID_FIRST, 32'h0);
        write_reg(REG_UID_SECOND, 32'hFFFF_FFFF);
        write_reg(REG_AUTO_CLOSE, 32'h0000_FFFF);
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd4, 32'h0));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd4, 32'hFFFF_FFFF));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd5, 32'h0));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'hF, 32'hFFFF_FFFF));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd4, 32'h1234_5678));
        wait_drained();
        write_reg(REG_UID_COUNT, 1);
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd4, 32'hFFFF_FFFF));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd4, 32'h0));
        wait_drained();
        write_reg(REG_UID_COUNT, 0);
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd4, 32'h0));
        wait_drained();
        write_reg(REG_UID_COUNT, 3);
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd4, 32'hFFFF_FFFF));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd8, 32'h0));
        wait_drained();
    endtask

    // The largest debounce threshold keeps the press from firing; the largest auto-close threshold is not reached here.
    task automatic test_counter_saturation();
        write_reg(REG_DEBOUNCE, 32'h0000_FFFF);
        write_reg(REG_AUTO_CLOSE, 32'h0000_FFFF);
        write_reg(REG_ANY_CARD, 1);
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd7, $urandom));
        for (int i = 0; i < 40; i++)
            send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0, 32'h0));
        wait_drained();
        write_reg(REG_DEBOUNCE, 32'h0000_FFFE);
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0, 32'h0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0, 32'h0));
        wait_drained();
    endtask

    task automatic randomize_config();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            write_reg(REG_DEBOUNCE, $urandom_range(0, 3));
        else if (pick < 9)
            write_reg(REG_DEBOUNCE, $urandom_range(4, 12));
        else
            write_reg(REG_DEBOUNCE, 32'h0000_FFFF);
        pick = $urandom_range(0, 9);
        if (pick < 6)
            write_reg(REG_AUTO_CLOSE, $urandom_range(0, 10));
        else if (pick < 9)
            write_reg(REG_AUTO_CLOSE, $urandom_range(11, 60));
        else
            write_reg(REG_AUTO_CLOSE, 32'h0000_FFFF);
        write_reg(REG_ANY_CARD, DATA_W'($urandom_range(0, 2) == 0));
        write_reg(REG_UID_FIRST, ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom);
        write_reg(REG_UID_SECOND, ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom);
        write_reg(REG_UID_COUNT, $urandom_range(0, 3));
    endtask

    // Mostly clean presses held past the debounce time, mixed with chatter.
    task automatic test_random_ticks(input int tx_pct, input int rx_pct, input int rounds);
        int sent;
        int hold;
        int kind;
        logic open_level;
        logic close_level;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int r = 0; r < rounds; r++) begin
            wait_drained();
            randomize_config();
            sent = 0;
            while (sent < 55) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    case ($urandom_range(0, 9))
                        0:       {open_level, close_level} = 2'b00;
                        1, 2, 3: {open_level, close_level} = 2'b01;
                        default: {open_level, close_level} = 2'b10;
                    endcase
                    hold = (cfg_debounce > 20) ? $urandom_range(1, 6)
                                               : cfg_debounce + $urandom_range(1, 4);
                    for (int i = 0; i < hold; i++)
                        send_tick(random_tick(open_level, close_level));
                    sent += hold;
                    hold = (cfg_debounce > 20) ? $urandom_range(1, 6)
                                               : cfg_debounce + $urandom_range(1, 3);
                    for (int i = 0; i < hold; i++)
                        send_tick(random_tick(1'b1, 1'b1));
                    sent += hold;
                end else begin
                    hold = $urandom_range(1, 4);
                    for (int i = 0; i < hold; i++)
                        send_tick(random_tick(1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1))));
                    sent += hold;
                end
                if ($urandom_range(0, 99) < 4)
                    wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        error_count = 0;
        cycle_count = 0;
        tx_idle_pct = 21;
        rx_idle_pct = 64;
        reset_lock_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_defaults();
        test_button_debounce();
        test_card_table();
        test_random_ticks(21, 64, 3);
        test_random_ticks(64, 21, 3);
        test_random_ticks(0, 0, 3);
        test_counter_saturation();

        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
